// File: rtl/mtcps_pkg.sv
// ----------------------------------------------------------------------------
// mtcps_pkg: shared constants for the median filtered sensor calibration
// Widths of fields, register indexes, status codes and default parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package mtcps_pkg;

  // default parameter values
  localparam int SAMPLE_COUNT_DEF = 20;
  localparam int ADC_BITS         = 12;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int TEMP_W   = 16;
  localparam int DATA_W   = 24;
  localparam int IDX_W    = 3;
  localparam int STAT_W   = 2;

  // samples wider than the converter are masked
  localparam logic [SAMPLE_W-1:0] ADC_MASK =
    SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_VOLT_SCALE  = 3'd0,
    REG_POLY_DEGREE = 3'd1,
    REG_COEFF_A0    = 3'd2,
    REG_COEFF_A1    = 3'd3,
    REG_COEFF_A2    = 3'd4,
    REG_COEFF_A3    = 3'd5,
    REG_CALIBRATED  = 3'd6
  } cfg_reg_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOT_CAL  = 2'd1,
    ST_BAD_DIV  = 2'd2,
    ST_PPM_SAT  = 2'd3
  } status_t;

  localparam logic [DATA_W-1:0] VOLT_SCALE_RST = 24'd13520;
  // -1.0 in Q16.8
  localparam logic signed [DATA_W-1:0] PPM_FAULT = -24'sd256;
  // 1 + 0.02*(T-25) == (T + 6400) / 12800 with T in Q8.8
  localparam logic signed [TEMP_W:0] TEMP_OFFSET = 17'sd6400;

endpackage

`default_nettype wire

// File: rtl/mtcps_ram.sv
// ----------------------------------------------------------------------------
// mtcps_ram: generic single write, single read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mtcps_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 20,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/median_temp_comp_poly_sensor_top.sv
// ----------------------------------------------------------------------------
// median_temp_comp_poly_sensor_top: median filtered sensor calibration
// Collects raw samples in a RAM, selects the median, compensates for
// temperature and applies a calibration polynomial.
// ----------------------------------------------------------------------------
// Every SAMPLE_COUNT-th input transfer produces one result; the others
// produce none. During collection each offered sample is taken at once.
// On the last sample the block stops taking input: the median is found
// by ranking every stored sample against all others through the single
// read port of the sample RAM, which takes most of that time; the
// temperature division is a restoring divider, and the polynomial terms
// share one multiplier, each term being formed in S_TERM and summed in
// S_ACC. A finished result waits in the output register while the next
// collection runs; if the previous result has not been taken yet, input
// stays stalled until it is.
// ----------------------------------------------------------------------------
`default_nettype none

module median_temp_comp_poly_sensor_top #(
  parameter int SAMPLE_COUNT = mtcps_pkg::SAMPLE_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // sample input
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [mtcps_pkg::SAMPLE_W-1:0]    in_adc_sample,
  input  wire logic signed [mtcps_pkg::TEMP_W-1:0] in_temperature,
  // result output
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [mtcps_pkg::DATA_W-1:0]    out_ppm,
  output logic [mtcps_pkg::DATA_W-1:0]           out_comp_voltage,
  output logic [mtcps_pkg::STAT_W-1:0]           out_status,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [mtcps_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [mtcps_pkg::DATA_W-1:0]      cfg_wdata
);

  localparam int SW  = mtcps_pkg::SAMPLE_W;
  localparam int DW  = mtcps_pkg::DATA_W;
  localparam int AW  = $clog2(SAMPLE_COUNT);
  localparam int CW  = $clog2(SAMPLE_COUNT + 1);
  localparam int NUMW = 47;
  localparam int DENW = 17;
  localparam int DCW  = 6;
  localparam int ACCW = 60;
  localparam logic [AW-1:0] LAST_IDX = AW'(SAMPLE_COUNT - 1);
  localparam logic [CW-1:0] K_LO     = CW'((SAMPLE_COUNT - 1) / 2);
  localparam logic [CW-1:0] K_HI     = CW'(SAMPLE_COUNT / 2);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(NUMW - 1);

  typedef enum logic [3:0] {
    S_COLLECT, S_CAND, S_CAPT, S_SCAN, S_TALLY, S_DECIDE,
    S_MUL1, S_MUL2, S_DIV, S_SQ, S_V2, S_CB, S_V3, S_TERM, S_ACC, S_DONE
  } state_t;

  // configuration registers
  logic [DW-1:0]        volt_scale_r;
  logic [1:0]           poly_degree_r;
  logic signed [DW-1:0] coeff_r [4];
  logic                 calibrated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_scale_r  <= mtcps_pkg::VOLT_SCALE_RST;
      poly_degree_r <= '0;
      for (int k = 0; k < 4; k++) begin
        coeff_r[k] <= '0;
      end
      calibrated_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtcps_pkg::REG_VOLT_SCALE:  volt_scale_r  <= cfg_wdata;
        mtcps_pkg::REG_POLY_DEGREE: poly_degree_r <= cfg_wdata[1:0];
        mtcps_pkg::REG_COEFF_A0:    coeff_r[0]    <= cfg_wdata;
        mtcps_pkg::REG_COEFF_A1:    coeff_r[1]    <= cfg_wdata;
        mtcps_pkg::REG_COEFF_A2:    coeff_r[2]    <= cfg_wdata;
        mtcps_pkg::REG_COEFF_A3:    coeff_r[3]    <= cfg_wdata;
        mtcps_pkg::REG_CALIBRATED:  calibrated_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // datapath registers
  state_t               state_r;
  logic [AW-1:0]        cnt_r;
  logic [AW-1:0]        i_r, j_r;
  logic [SW-1:0]        cand_r, lo_r, hi_r;
  logic [CW-1:0]        lt_r, le_r;
  logic                 scan_vld_r;
  logic signed [mtcps_pkg::TEMP_W-1:0] temp_r;
  logic [36:0]          raw_r;
  logic [NUMW-1:0]      num_r;
  logic [DENW-1:0]      den_r;
  logic [DENW:0]        rem_r;
  logic [DCW-1:0]       dcnt_r;
  logic                 bad_r;
  logic [DW-1:0]        cv_r;
  logic [51:0]          prod_r;
  logic [27:0]          v2_r;
  logic [31:0]          v3_r;
  logic [1:0]           k_r;
  logic signed [57:0]   term_r;
  logic signed [ACCW-1:0] acc_r;
  logic                 out_valid_r;
  logic signed [DW-1:0] ppm_r;
  logic [DW-1:0]        cvo_r;
  logic [mtcps_pkg::STAT_W-1:0] stat_r;

  // sample RAM
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  logic          in_xfer;

  assign in_ready = (state_r == S_COLLECT);
  assign in_xfer  = in_valid && in_ready;
  assign ram_we   = in_xfer;

  always_comb begin
    case (state_r)
      S_CAND:  ram_raddr = i_r;
      default: ram_raddr = j_r;
    endcase
  end

  mtcps_ram #(
    .WIDTH (SW),
    .DEPTH (SAMPLE_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r),
    .wdata (in_adc_sample & mtcps_pkg::ADC_MASK),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // compensation divisor and scaled numerator
  logic signed [DENW-1:0] den_s;
  logic                   den_bad;
  logic [NUMW-1:0]        raw_x400;
  assign den_s    = DENW'(signed'(temp_r)) + mtcps_pkg::TEMP_OFFSET;
  assign den_bad  = den_s[DENW-1] || (den_s == '0);
  assign raw_x400 = (NUMW'(raw_r) << 8) + (NUMW'(raw_r) << 7) + (NUMW'(raw_r) << 4);

  // restoring divider step
  logic [DENW:0] rem_sh;
  logic          rem_ge;
  assign rem_sh = {rem_r[DENW-1:0], num_r[NUMW-1]};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  // polynomial term operands
  logic signed [33:0]   v_sel;
  logic signed [DW-1:0] c_sel;
  always_comb begin
    case (k_r)
      2'd0:    v_sel = 34'sd1048576;
      2'd1:    v_sel = 34'(cv_r);
      2'd2:    v_sel = 34'(v2_r);
      default: v_sel = 34'(v3_r);
    endcase
    c_sel = coeff_r[k_r];
  end

  // final rounding and saturation
  logic signed [ACCW-1:0] acc_rnd;
  logic signed [35:0]     ppm_full;
  logic                   ppm_hi, ppm_lo;
  assign acc_rnd  = acc_r + ACCW'(64'sd8388608);
  assign ppm_full = 36'(acc_rnd >>> 24);
  assign ppm_hi   = ppm_full > 36'sd8388607;
  assign ppm_lo   = ppm_full < -36'sd8388608;

  logic out_load;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      scan_vld_r  <= 1'b0;
    end else begin
      scan_vld_r <= (state_r == S_SCAN);
      // output register: load a new result or retire the taken one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // rank compare of the scanned sample against the candidate
      if (scan_vld_r) begin
        if (ram_rdata < cand_r) lt_r <= lt_r + 1'b1;
        if (ram_rdata <= cand_r) le_r <= le_r + 1'b1;
      end
      unique case (state_r)
        S_COLLECT: begin
          if (in_xfer) begin
            if (cnt_r == LAST_IDX) begin
              cnt_r   <= '0;
              temp_r  <= in_temperature;
              i_r     <= '0;
              state_r <= S_CAND;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_CAND: state_r <= S_CAPT;
        S_CAPT: begin
          cand_r  <= ram_rdata;
          lt_r    <= '0;
          le_r    <= '0;
          j_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          j_r <= j_r + 1'b1;
          if (j_r == LAST_IDX) state_r <= S_TALLY;
        end
        S_TALLY: state_r <= S_DECIDE;
        S_DECIDE: begin
          if ((lt_r <= K_LO) && (K_LO < le_r)) lo_r <= cand_r;
          if ((lt_r <= K_HI) && (K_HI < le_r)) hi_r <= cand_r;
          i_r <= i_r + 1'b1;
          state_r <= (i_r == LAST_IDX) ? S_MUL1 : S_CAND;
        end
        S_MUL1: begin
          raw_r   <= 37'(({1'b0, lo_r} + {1'b0, hi_r}) * volt_scale_r);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          bad_r  <= den_bad;
          den_r  <= den_s;
          num_r  <= raw_x400 + NUMW'(den_s[DENW-1:1]);
          rem_r  <= '0;
          dcnt_r <= '0;
          if (den_bad) begin
            cv_r    <= '0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r  <= rem_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
          num_r  <= {num_r[NUMW-2:0], rem_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DIV_LAST) begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          // quotient is complete in num_r
          cv_r    <= (num_r > NUMW'(24'hFFFFFF)) ? 24'hFFFFFF : num_r[DW-1:0];
          state_r <= calibrated_r ? S_V2 : S_DONE;
        end
        S_V2: begin
          prod_r  <= 52'(cv_r * cv_r);
          state_r <= S_CB;
        end
        S_CB: begin
          v2_r    <= 28'((prod_r + 52'd524288) >> 20);
          state_r <= S_V3;
        end
        S_V3: begin
          prod_r  <= 52'(v2_r * cv_r);
          acc_r   <= '0;
          k_r     <= '0;
          state_r <= S_TERM;
        end
        S_TERM: begin
          term_r  <= 58'(c_sel * v_sel);
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= acc_r + ACCW'(term_r);
          if (k_r == 2'd2) begin
            v3_r <= 32'((prod_r + 52'd524288) >> 20);
          end
          if (k_r == poly_degree_r) begin
            state_r <= S_DONE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_TERM;
          end
        end
        S_DONE: begin
          if (out_load) begin
            cvo_r       <= cv_r;
            if (!calibrated_r) begin
              ppm_r  <= mtcps_pkg::PPM_FAULT;
              stat_r <= mtcps_pkg::ST_NOT_CAL;
            end else if (bad_r) begin
              ppm_r  <= mtcps_pkg::PPM_FAULT;
              stat_r <= mtcps_pkg::ST_BAD_DIV;
            end else if (ppm_hi) begin
              ppm_r  <= 24'sh7FFFFF;
              stat_r <= mtcps_pkg::ST_PPM_SAT;
            end else if (ppm_lo) begin
              ppm_r  <= -24'sh800000;
              stat_r <= mtcps_pkg::ST_PPM_SAT;
            end else begin
              ppm_r  <= ppm_full[DW-1:0];
              stat_r <= mtcps_pkg::ST_OK;
            end
            state_r <= S_COLLECT;
          end
        end
        default: state_r <= S_COLLECT;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ppm          = ppm_r;
  assign out_comp_voltage = cvo_r;
  assign out_status       = stat_r;

  // a result only appears once a batch of samples has been completed
  a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (cnt_r == '0))
    else $error("result without a completed batch");

  // a bad divisor never reports a compensated voltage
  a_bad_cv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status == mtcps_pkg::ST_BAD_DIV)) |-> (out_comp_voltage == '0))
    else $error("bad divisor with nonzero voltage");

  // the not calibrated status carries the fault ppm value
  a_fault_ppm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status == mtcps_pkg::ST_NOT_CAL)) |-> (out_ppm == mtcps_pkg::PPM_FAULT))
    else $error("not calibrated with wrong ppm");

endmodule

`default_nettype wire
